/* hdl/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg: shared types and constants of the periodic event scheduler
// Table size, operation and status codes, the entry record carried by each
// cell, the cell control word and the ordering function on entry keys.
// ----------------------------------------------------------------------------
package pes_pkg;

   localparam int MAX_SOURCES = 64;
   localparam int SLOT_W      = $clog2(MAX_SOURCES);
   localparam int CNT_W       = $clog2(MAX_SOURCES + 1);

   localparam int FUNC_W   = 2;
   localparam int ID_W     = 32;
   localparam int PERIOD_W = 24;
   localparam int TIME_W   = 48;
   localparam int STATUS_W = 3;

   localparam logic [FUNC_W-1:0] FUNC_REGISTER = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DISPATCH = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR    = 2'd2;

   localparam logic [STATUS_W-1:0] ST_DISPATCHED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DONE       = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FULL       = 3'd2;
   localparam logic [STATUS_W-1:0] ST_EMPTY      = 3'd3;
   localparam logic [STATUS_W-1:0] ST_SATURATED  = 3'd4;

   typedef enum logic {
      PES_IDLE,
      PES_REINSERT
   } pes_state_type;

   // one table entry; slot is the registration order and breaks full ties
   typedef struct packed {
      logic [TIME_W-1:0]   due;
      logic [ID_W-1:0]     id;
      logic [PERIOD_W-1:0] period;
      logic [SLOT_W-1:0]   slot;
   } pes_entry_type;

   typedef struct packed {
      logic shift;
      logic insert;
   } pes_ctl_type;

   // order by due time, then identifier, then slot
   function automatic logic key_less(input pes_entry_type a, input pes_entry_type b);
      return {a.due, a.id, a.slot} < {b.due, b.id, b.slot};
   endfunction

endpackage

/* hdl/periodic_event_scheduler.sv */
// ----------------------------------------------------------------------------
// periodic_event_scheduler: min-priority scheduler of periodic sources
// Sorted chain of cells keeps registered sources ordered by due time.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one item: func, source_id and period. Register
//   adds a source due first at its period, dispatch pops the earliest source
//   and puts it back one period later, clear empties the table.
//   Every item gives exactly one result item on the rsp_ channel: the served
//   identifier and fire time (zero when nothing fired) and a status code.
//   The result is registered and shows in the cycle after acceptance.
//   Register, clear and unknown items leave the block free for the next
//   item; a dispatch raises req_stall while the chain first shifts the head
//   out and then sorts the advanced entry back in.
//   The chain holds MAX_SOURCES cells; each cell compares the key being
//   inserted against its own, so an insert needs no search through the chain.
//   Reset empties the table at once (fill count to zero); cell contents are
//   left as they are and never read before written.
//   A stall on rsp_ holds the result; req_stall then rises until the result
//   is taken, since the output register is the only result buffer.
// ----------------------------------------------------------------------------
module periodic_event_scheduler import pes_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [FUNC_W-1:0]   req_func,
   input  logic [ID_W-1:0]     req_source_id,
   input  logic [PERIOD_W-1:0] req_period,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [ID_W-1:0]     rsp_served_id,
   output logic [TIME_W-1:0]   rsp_served_time,
   output logic [STATUS_W-1:0] rsp_status
);

   localparam logic [TIME_W:0] TIME_MAX = {1'b0, {TIME_W{1'b1}}};

   pes_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]     served_id_ff, served_id_in;
   logic [TIME_W-1:0]   served_time_ff, served_time_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   pes_entry_type       hold_ff, hold_in;

   pes_ctl_type   ctl;
   pes_entry_type new_entry;
   pes_entry_type reg_entry;
   pes_entry_type cell_entry [MAX_SOURCES];
   logic          cell_less  [MAX_SOURCES];
   logic          accept;
   logic          full;
   logic          empty;
   logic [TIME_W:0] next_sum;

   // ---- the chain ----------------------------------------------------------
   for (genvar i = 0; i < MAX_SOURCES; i++) begin : g_cell
      pes_entry_type left_e, right_e;
      logic          left_l;
      if (i == 0) begin : g_head
         assign left_e = new_entry;
         assign left_l = 1'b0;
      end else begin : g_body
         assign left_e = cell_entry[i-1];
         assign left_l = cell_less[i-1];
      end
      if (i == MAX_SOURCES - 1) begin : g_tail
         assign right_e = cell_entry[i];
      end else begin : g_mid
         assign right_e = cell_entry[i+1];
      end
      pes_cell u_cell (
         .clock       (clock),
         .ctl         (ctl),
         .occupied    (count_ff > CNT_W'(i)),
         .new_entry   (new_entry),
         .left_entry  (left_e),
         .left_less   (left_l),
         .right_entry (right_e),
         .entry       (cell_entry[i]),
         .less        (cell_less[i])
      );
   end

   // ---- control ------------------------------------------------------------
   assign full  = (count_ff == CNT_W'(MAX_SOURCES));
   assign empty = (count_ff == '0);

   // new source: first due time equals its period, slot is the fill count at registration
   assign reg_entry.due    = TIME_W'(req_period);
   assign reg_entry.id     = req_source_id;
   assign reg_entry.period = req_period;
   assign reg_entry.slot   = count_ff[SLOT_W-1:0];

   // advance the head by its period, saturate at the top of the time range
   assign next_sum = {1'b0, cell_entry[0].due} + (TIME_W + 1)'(cell_entry[0].period);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      hold_in        = hold_ff;
      served_id_in   = served_id_ff;
      served_time_in = served_time_ff;
      status_in      = status_ff;
      ctl            = '0;
      new_entry      = reg_entry;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      req_stall      = rsp_valid_ff && rsp_stall;
      accept         = 1'b0;

      case (state_ff)
         PES_IDLE: begin
            accept = req_valid && !req_stall;
            if (accept) begin
               rsp_valid_in   = 1'b1;
               served_id_in   = '0;
               served_time_in = '0;
               status_in      = ST_DONE;
               case (req_func)
                  FUNC_REGISTER: begin
                     if (full) begin
                        status_in = ST_FULL;
                     end else begin
                        ctl.insert = 1'b1;
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  FUNC_DISPATCH: begin
                     if (empty) begin
                        status_in = ST_EMPTY;
                     end else begin
                        // pop the head now, sort it back in next cycle
                        ctl.shift      = 1'b1;
                        count_in       = count_ff - CNT_W'(1);
                        served_id_in   = cell_entry[0].id;
                        served_time_in = cell_entry[0].due;
                        hold_in        = cell_entry[0];
                        if (next_sum > TIME_MAX) begin
                           hold_in.due = {TIME_W{1'b1}};
                           status_in   = ST_SATURATED;
                        end else begin
                           hold_in.due = next_sum[TIME_W-1:0];
                           status_in   = ST_DISPATCHED;
                        end
                        state_in = PES_REINSERT;
                     end
                  end
                  FUNC_CLEAR: begin
                     count_in = '0;
                  end
                  default: begin
                     // unknown operation: no change, plain acknowledge
                  end
               endcase
            end
         end
         PES_REINSERT: begin
            req_stall  = 1'b1;
            new_entry  = hold_ff;
            ctl.insert = 1'b1;
            count_in   = count_ff + CNT_W'(1);
            state_in   = PES_IDLE;
         end
         default: begin
            state_in = PES_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PES_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff        <= hold_in;
      served_id_ff   <= served_id_in;
      served_time_ff <= served_time_in;
      status_ff      <= status_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_served_id   = served_id_ff;
   assign rsp_served_time = served_time_ff;
   assign rsp_status      = status_ff;

   // ---- checks -------------------------------------------------------------
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_SOURCES))
      else $error("fill count exceeds table size");

   a_dispatch_reinsert: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_DISPATCH && !empty) |=> (state_ff == PES_REINSERT))
      else $error("dispatch not followed by reinsert");

   a_head_sorted: assert property (@(posedge clock) disable iff (reset)
      (state_ff == PES_IDLE && count_ff >= CNT_W'(2))
         |-> !key_less(cell_entry[1], cell_entry[0]))
      else $error("chain head is not the minimum");

   a_full_no_grow: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_REGISTER && full) |=> (count_ff == CNT_W'(MAX_SOURCES)))
      else $error("register into full table changed count");

endmodule

/* hdl/pes_cell.sv */
// ----------------------------------------------------------------------------
// pes_cell: one slot of the sorted entry chain
// Holds one entry. Shift takes the right neighbor's entry; insert keeps the
// entry, takes the left neighbor's, or takes the new one, by key order.
// ----------------------------------------------------------------------------
module pes_cell import pes_pkg::*; (
   input  logic          clock,
   input  pes_ctl_type   ctl,
   input  logic          occupied,
   input  pes_entry_type new_entry,
   input  pes_entry_type left_entry,
   input  logic          left_less,
   input  pes_entry_type right_entry,
   output pes_entry_type entry,
   output logic          less
);

   pes_entry_type entry_ff;
   pes_entry_type entry_in;

   // an empty cell ranks after any key
   assign less  = !occupied || key_less(new_entry, entry_ff);
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.shift) begin
         entry_in = right_entry;
      end else if (ctl.insert && less) begin
         entry_in = left_less ? left_entry : new_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule
